>>> src/rrts_pkg.sv
// shared types, codes and constants for the round-robin thread scheduler
package rrts_pkg;

    // default sizing
    localparam int MAX_THREADS_DEF  = 8;
    localparam int THREAD_BYTES_DEF = 1024;

    // item kinds
    localparam logic [2:0] KIND_CREATE = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_TICK   = 3'd2;
    localparam logic [2:0] KIND_YIELD  = 3'd3;
    localparam logic [2:0] KIND_SWITCH = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_STACK_TOP     = 2'd0;
    localparam logic [1:0] CFG_MAX_STACK     = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_SLICE = 2'd2;

    // configuration reset values
    localparam logic [31:0] STACK_TOP_RST     = 32'd536903680;
    localparam logic [20:0] MAX_STACK_RST     = 21'd16384;
    localparam logic [15:0] DEFAULT_SLICE_RST = 16'd5;

    // initial frame skipped on create, adjustment applied on save
    localparam logic [31:0] FRAME_BYTES = 32'd64;
    localparam logic [31:0] SAVE_ADJUST = 32'd32;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] slice_ticks;
        logic [31:0] current_psp;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [31:0] stack_addr;
        logic [31:0] next_sp;
        logic [2:0]  thread_index;
        logic        switch_request;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic more;
    } t_sts;

endpackage

>>> src/rrts_ctrl.sv
// sequencing state machine for the thread scheduler
module rrts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  rrts_pkg::t_sts i_sts,
    output rrts_pkg::t_cmd o_cmd
);
    import rrts_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_READ2  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.more ? S_READ2 : S_OUT;
            end
            S_READ2: begin
                o_cmd.read = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

>>> src/rrts_datapath.sv
// thread table, configuration registers and per-kind execution
module rrts_datapath #(
    parameter int MAX_THREADS  = rrts_pkg::MAX_THREADS_DEF,
    parameter int THREAD_BYTES = rrts_pkg::THREAD_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  rrts_pkg::t_in_item i_item,
    input  rrts_pkg::t_cmd     i_cmd,
    output rrts_pkg::t_sts     o_sts,
    output rrts_pkg::t_out_item o_item
);
    import rrts_pkg::*;

    localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int TW = $clog2(MAX_THREADS + 1);

    // configuration
    logic [31:0] r_stack_top;
    logic [20:0] r_max_stack;
    logic [15:0] r_default_slice;

    // scheduler state
    logic [TW-1:0] r_total, n_total;
    logic [IW-1:0] r_cur, n_cur;
    logic          r_running, n_running;

    // captured item
    logic [2:0]  r_kind;
    logic [15:0] r_slice_in;
    logic [31:0] r_psp;

    // thread table
    logic [31:0] r_sp_mem  [MAX_THREADS];
    logic [15:0] r_len_mem [MAX_THREADS];
    logic [15:0] r_tk_mem  [MAX_THREADS];

    // registered table reads and create addresses
    logic [31:0] r_sp_q;
    logic [15:0] r_len_q;
    logic [15:0] r_tk_q;
    logic [31:0] r_addr;
    logic [31:0] r_floor;

    t_out_item r_res, n_res;

    logic          w_have;
    logic          w_full;
    logic [15:0]   w_slice;
    logic [15:0]   w_dec;
    logic [TW-1:0] w_next_t;
    logic [IW-1:0] w_next;
    logic [IW-1:0] w_raddr;
    logic [IW-1:0] w_waddr;
    logic [31:0]   w_span;
    logic          w_sp_we, w_len_we, w_tk_we;
    logic [31:0]   w_sp_wd;
    logic [15:0]   w_tk_wd;
    logic          w_more;

    // address helpers
    always_comb begin
        w_have   = (r_total != '0) && (TW'(r_cur) < r_total);
        w_full   = (r_total >= TW'(MAX_THREADS));
        w_slice  = (r_slice_in != 16'd0) ? r_slice_in : r_default_slice;
        w_dec    = r_tk_q - 16'd1;
        w_next_t = TW'(r_cur) + TW'(1);
        w_next   = (w_next_t == r_total) ? '0 : IW'(w_next_t);
        w_raddr  = (r_kind == KIND_START) ? '0 : r_cur;
        w_waddr  = (r_kind == KIND_CREATE) ? IW'(r_total) : r_cur;
        w_span   = (32'(r_total) + 32'd1) * 32'(THREAD_BYTES);
    end

    // per-kind execution
    always_comb begin
        n_res     = '0;
        n_total   = r_total;
        n_cur     = r_cur;
        n_running = r_running;
        w_sp_we   = 1'b0;
        w_len_we  = 1'b0;
        w_tk_we   = 1'b0;
        w_sp_wd   = '0;
        w_tk_wd   = '0;
        w_more    = 1'b0;
        case (r_kind)
            KIND_CREATE: begin
                if (w_full || (r_addr < r_floor)) begin
                    n_res.status = 1'b1;
                end else begin
                    w_sp_we            = 1'b1;
                    w_len_we           = 1'b1;
                    w_tk_we            = 1'b1;
                    w_sp_wd            = r_addr - FRAME_BYTES;
                    w_tk_wd            = w_slice;
                    n_total            = r_total + TW'(1);
                    n_res.stack_addr   = r_addr;
                    n_res.thread_index = 3'(r_total);
                end
            end
            KIND_START: begin
                n_running = 1'b1;
                n_cur     = '0;
                if (r_total == '0) begin
                    n_res.status = 1'b1;
                end else begin
                    n_res.next_sp = r_sp_q;
                end
            end
            KIND_TICK: begin
                if (r_running && w_have) begin
                    w_tk_we            = 1'b1;
                    n_res.thread_index = 3'(r_cur);
                    if (w_dec == 16'd0) begin
                        w_tk_wd              = r_len_q;
                        n_res.switch_request = 1'b1;
                    end else begin
                        w_tk_wd = w_dec;
                    end
                end
            end
            KIND_YIELD: begin
                if (w_have) begin
                    w_tk_we              = 1'b1;
                    w_tk_wd              = r_len_q;
                    n_res.switch_request = 1'b1;
                    n_res.thread_index   = 3'(r_cur);
                end else begin
                    n_res.status = 1'b1;
                end
            end
            KIND_SWITCH: begin
                if (w_have) begin
                    w_sp_we = 1'b1;
                    w_sp_wd = r_psp - SAVE_ADJUST;
                    n_cur   = w_next;
                    w_more  = 1'b1;
                end else begin
                    n_res.status = 1'b1;
                end
            end
            default: begin
                n_res.status = 1'b1;
            end
        endcase
    end

    assign o_sts.more = w_more;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_top     <= STACK_TOP_RST;
            r_max_stack     <= MAX_STACK_RST;
            r_default_slice <= DEFAULT_SLICE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STACK_TOP:     r_stack_top     <= i_cfg_data;
                CFG_MAX_STACK:     r_max_stack     <= i_cfg_data[20:0];
                CFG_DEFAULT_SLICE: r_default_slice <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // scheduler control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_cur     <= '0;
            r_running <= 1'b0;
        end else if (i_cmd.exec) begin
            r_total   <= n_total;
            r_cur     <= n_cur;
            r_running <= n_running;
        end
    end

    // item capture, create address math and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind     <= i_item.kind;
            r_slice_in <= i_item.slice_ticks;
            r_psp      <= i_item.current_psp;
        end
        if (i_cmd.read) begin
            r_addr  <= r_stack_top - w_span;
            r_floor <= r_stack_top - 32'(r_max_stack) - 32'(THREAD_BYTES);
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end else if (i_cmd.finish) begin
            r_res.next_sp      <= r_sp_q;
            r_res.thread_index <= 3'(r_cur);
        end
    end

    // saved stack pointer table
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_sp_we) begin
            r_sp_mem[w_waddr] <= w_sp_wd;
        end
        if (i_cmd.read) begin
            r_sp_q <= r_sp_mem[w_raddr];
        end
    end

    // slice length table
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_len_we) begin
            r_len_mem[w_waddr] <= w_slice;
        end
        if (i_cmd.read) begin
            r_len_q <= r_len_mem[w_raddr];
        end
    end

    // ticks left table
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_tk_we) begin
            r_tk_mem[w_waddr] <= w_tk_wd;
        end
        if (i_cmd.read) begin
            r_tk_q <= r_tk_mem[w_raddr];
        end
    end

    assign o_item = r_res;

endmodule

>>> src/round_robin_thread_scheduler.sv
// top level of the round-robin time-slice thread scheduler
//
// Input channel: i_in_valid / o_in_stall with i_item (kind, slice_ticks,
// current_psp). An item is taken at a clock edge with valid high and stall
// low. Output channel: o_out_valid / i_out_stall with o_item; every item
// gives exactly one result item.
// Steps: the thread table is read, the item is executed and the result
// is presented; a switch adds a second table read of the incoming
// thread's stack pointer before the result is presented.
// The block takes one item at a time: a new item is taken only once the
// result has been accepted. While the receiver stalls the result is held
// and no new item is taken.
// Configuration (stack_top, max_stack, default_slice) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while no
// item is in flight, as the block itself does not enforce this.
// Reset (synchronous, active low) empties the thread table, clears the
// running flag and restores the configuration defaults; table entries are
// only read after create has written them, so no clearing pass is needed.
module round_robin_thread_scheduler #(
    parameter int MAX_THREADS  = rrts_pkg::MAX_THREADS_DEF,
    parameter int THREAD_BYTES = rrts_pkg::THREAD_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rrts_pkg::t_in_item  i_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rrts_pkg::t_out_item o_item
);
    import rrts_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    rrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // thread table and execution
    rrts_datapath #(
        .MAX_THREADS  (MAX_THREADS),
        .THREAD_BYTES (THREAD_BYTES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_item     (o_item)
    );

endmodule
